// ===== src/i2cms_pkg.sv =====
// Shared types and constants for the I2C master transaction sequencer.
// No dependencies.
`timescale 1ns / 1ps

package i2cms_pkg;

  // Width of the remaining-byte counter
  localparam int COUNT_WIDTH = 8;

  // Input beat kinds
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_EVENT   = 1'b1;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_ADDR  = 3'd2,
    PH_DATA  = 3'd3,
    PH_LAST  = 3'd4
  } phase_t;

  // Bus engine commands
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_GO    = 3'd2,
    CMD_ACK   = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_t;

  // Transaction outcomes
  typedef enum logic [2:0] {
    RES_OK         = 3'd0,
    RES_START_FAIL = 3'd1,
    RES_ADDR_NACK  = 3'd2,
    RES_DATA_NACK  = 3'd3,
    RES_LAST_FAIL  = 3'd4
  } outcome_t;

  // Expected engine status codes (after masking)
  localparam logic [7:0] ST_START  = 8'h08;
  localparam logic [7:0] ST_R_ADDR = 8'h40;
  localparam logic [7:0] ST_R_DATA = 8'h50;
  localparam logic [7:0] ST_R_LAST = 8'h58;
  localparam logic [7:0] ST_W_ADDR = 8'h18;
  localparam logic [7:0] ST_W_DATA = 8'h28;
  localparam logic [7:0] ST_MASK   = 8'hF8;
  localparam logic       DIR_READ  = 1'b1;

endpackage

// ===== src/i2c_master_transaction_sequencer.sv =====
// I2C master transaction sequencer: phase control above a byte-level bus engine.
// Depends on i2cms_pkg.
// An accepted input beat's result beat is registered in the out_* regs on the next cycle.
// Throughput: one beat per cycle; the result register drains while the next beat
// is decided, so input stalls only when a result is held and the output stalls.
// Reset (rst_n low, synchronous): phase idle, byte counter, direction and address
// cleared, output register empty.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic       in_read_not_write,
  input  logic [6:0] in_target_address,
  input  logic [7:0] in_byte_count,
  input  logic [7:0] in_status_code,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_tx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_command,
  output logic       out_load_valid,
  output logic [7:0] out_load_byte,
  output logic       out_data_valid,
  output logic [7:0] out_data_byte,
  output logic       out_done_res,
  output logic [2:0] out_outcome
);
  import i2cms_pkg::*;

  // Transaction state
  phase_t                 phase_r, phase_nxt;
  logic                   reading_r, reading_nxt;
  logic [6:0]             dev_addr_r, dev_addr_nxt;
  logic [COUNT_WIDTH-1:0] bytes_left_r, bytes_left_nxt;

  // Result register
  logic       out_valid_r;
  cmd_t       command_r, command_nxt;
  logic       load_valid_r, load_valid_nxt;
  logic [7:0] load_byte_r, load_byte_nxt;
  logic       data_valid_r, data_valid_nxt;
  logic [7:0] data_byte_r, data_byte_nxt;
  logic       done_r, done_nxt;
  outcome_t   outcome_r, outcome_nxt;

  logic                   accept;
  logic [7:0]             st;
  logic                   ok_start, ok_addr, ok_data, ok_last;
  logic [COUNT_WIDTH-1:0] bytes_dec;
  logic                   left_zero, left_one, dec_zero, dec_le_one;

  // Handshake: stall only while a held result cannot drain
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Status checks against the current phase
  assign st       = in_status_code & ST_MASK;
  assign ok_start = (st == ST_START);
  assign ok_addr  = (st == (reading_r ? ST_R_ADDR : ST_W_ADDR));
  assign ok_data  = (st == (reading_r ? ST_R_DATA : ST_W_DATA));
  assign ok_last  = (st == ST_R_LAST);

  // Byte counter tests
  assign bytes_dec  = bytes_left_r - COUNT_WIDTH'(1);
  assign left_zero  = (bytes_left_r == '0);
  assign left_one   = (bytes_left_r == COUNT_WIDTH'(1));
  assign dec_zero   = (bytes_dec == '0);
  assign dec_le_one = (bytes_dec <= COUNT_WIDTH'(1));

  // Next state
  always_comb begin
    phase_nxt      = phase_r;
    reading_nxt    = reading_r;
    dev_addr_nxt   = dev_addr_r;
    bytes_left_nxt = bytes_left_r;
    if (in_op == OP_REQUEST) begin
      if (phase_r == PH_IDLE) begin
        reading_nxt    = in_read_not_write;
        dev_addr_nxt   = in_target_address;
        bytes_left_nxt = COUNT_WIDTH'(in_byte_count);
        phase_nxt      = PH_START;
      end
    end else begin
      case (phase_r)
        PH_START: begin
          phase_nxt = ok_start ? PH_ADDR : PH_IDLE;
        end
        PH_ADDR: begin
          if (!ok_addr || left_zero) begin
            phase_nxt = PH_IDLE;
          end else if (reading_r && left_one) begin
            phase_nxt = PH_LAST;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if (!ok_data) begin
            phase_nxt = PH_IDLE;
          end else begin
            bytes_left_nxt = bytes_dec;
            if (reading_r) begin
              if (dec_le_one) phase_nxt = PH_LAST;
            end else if (dec_zero) begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_LAST: begin
          if (ok_last) bytes_left_nxt = '0;
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Result beat
  always_comb begin
    command_nxt    = CMD_NONE;
    load_valid_nxt = 1'b0;
    load_byte_nxt  = '0;
    data_valid_nxt = 1'b0;
    data_byte_nxt  = '0;
    done_nxt       = 1'b0;
    outcome_nxt    = RES_OK;
    if (in_op == OP_REQUEST) begin
      if (phase_r == PH_IDLE) command_nxt = CMD_START;
    end else begin
      case (phase_r)
        PH_START: begin
          if (!ok_start) begin
            // failed start: no stop on the bus
            done_nxt    = 1'b1;
            outcome_nxt = RES_START_FAIL;
          end else begin
            command_nxt    = CMD_GO;
            load_valid_nxt = 1'b1;
            load_byte_nxt  = {dev_addr_r, reading_r ? DIR_READ : 1'b0};
          end
        end
        PH_ADDR: begin
          if (!ok_addr) begin
            command_nxt = CMD_STOP;
            done_nxt    = 1'b1;
            outcome_nxt = RES_ADDR_NACK;
          end else if (left_zero) begin
            command_nxt = CMD_STOP;
            done_nxt    = 1'b1;
          end else if (reading_r) begin
            command_nxt = left_one ? CMD_GO : CMD_ACK;
          end else begin
            command_nxt    = CMD_GO;
            load_valid_nxt = 1'b1;
            load_byte_nxt  = in_tx_byte;
          end
        end
        PH_DATA: begin
          if (!ok_data) begin
            command_nxt = CMD_STOP;
            done_nxt    = 1'b1;
            outcome_nxt = RES_DATA_NACK;
          end else if (reading_r) begin
            data_valid_nxt = 1'b1;
            data_byte_nxt  = in_rx_byte;
            command_nxt    = dec_le_one ? CMD_GO : CMD_ACK;
          end else if (dec_zero) begin
            command_nxt = CMD_STOP;
            done_nxt    = 1'b1;
          end else begin
            command_nxt    = CMD_GO;
            load_valid_nxt = 1'b1;
            load_byte_nxt  = in_tx_byte;
          end
        end
        PH_LAST: begin
          command_nxt = CMD_STOP;
          done_nxt    = 1'b1;
          if (!ok_last) begin
            outcome_nxt = RES_LAST_FAIL;
          end else begin
            data_valid_nxt = 1'b1;
            data_byte_nxt  = in_rx_byte;
          end
        end
        default: begin
          command_nxt = CMD_NONE;
        end
      endcase
    end
  end

  // State registers, updated per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      reading_r    <= 1'b0;
      dev_addr_r   <= '0;
      bytes_left_r <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      reading_r    <= reading_nxt;
      dev_addr_r   <= dev_addr_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      command_r    <= command_nxt;
      load_valid_r <= load_valid_nxt;
      load_byte_r  <= load_byte_nxt;
      data_valid_r <= data_valid_nxt;
      data_byte_r  <= data_byte_nxt;
      done_r       <= done_nxt;
      outcome_r    <= outcome_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_command    = command_r;
  assign out_load_valid = load_valid_r;
  assign out_load_byte  = load_byte_r;
  assign out_data_valid = data_valid_r;
  assign out_data_byte  = data_byte_r;
  assign out_done_res   = done_r;
  assign out_outcome    = outcome_r;

endmodule

// ===== bench/i2c_master_transaction_sequencer_tb.sv =====
// Self-checking bench for the I2C master transaction sequencer: drives request and
// bus-event beats, predicts every reply beat and checks it against the result port.
// Depends on i2cms_pkg and i2c_master_transaction_sequencer.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_tb;
  import i2cms_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASE_BEATS = 400;

  // One input beat, as driven onto the in_* ports
  typedef struct packed {
    logic       op;
    logic       rnw;
    logic [6:0] addr;
    logic [7:0] cnt;
    logic [7:0] status;
    logic [7:0] rx;
    logic [7:0] tx;
  } beat_t;

  // One reply beat, as seen on the out_* ports
  typedef struct packed {
    cmd_t       command;
    logic       load_valid;
    logic [7:0] load_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       ended;
    outcome_t   outcome;
  } reply_t;

  // Transaction tracker: mirrors the sequencer phase and holds pending replies
  class txn_scoreboard;
    phase_t                 phase;
    logic                   reading;
    logic [6:0]             dev_addr;
    logic [COUNT_WIDTH-1:0] left;
    reply_t                 expected_replies[$];
    int                     errors;
    int                     replies_seen;

    function new();
      phase        = PH_IDLE;
      reading      = 1'b0;
      dev_addr     = '0;
      left         = '0;
      errors       = 0;
      replies_seen = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH reply %0d: %s", replies_seen, msg);
      errors++;
    endtask

    // transaction ends with this beat
    function void conclude(inout reply_t r, input cmd_t c, input outcome_t o);
      r.command = c;
      r.ended   = 1'b1;
      r.outcome = o;
      phase     = PH_IDLE;
    endfunction

    function reply_t predict_reply(input beat_t b);
      reply_t     r;
      logic [7:0] st;
      r  = '0;
      st = b.status & ST_MASK;
      // requests only start a transaction from idle
      if (b.op == OP_REQUEST) begin
        if (phase == PH_IDLE) begin
          reading   = b.rnw;
          dev_addr  = b.addr;
          left      = b.cnt;
          phase     = PH_START;
          r.command = CMD_START;
        end
        return r;
      end
      case (phase)
        PH_START: begin
          if (st != ST_START) begin
            conclude(r, CMD_NONE, RES_START_FAIL);
          end else begin
            r.command    = CMD_GO;
            r.load_valid = 1'b1;
            r.load_byte  = {dev_addr, reading};
            phase        = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if (st != (reading ? ST_R_ADDR : ST_W_ADDR)) begin
            conclude(r, CMD_STOP, RES_ADDR_NACK);
          end else if (left == 0) begin
            conclude(r, CMD_STOP, RES_OK);
          end else if (reading) begin
            if (left == 1) begin
              r.command = CMD_GO;
              phase     = PH_LAST;
            end else begin
              r.command = CMD_ACK;
              phase     = PH_DATA;
            end
          end else begin
            r.command    = CMD_GO;
            r.load_valid = 1'b1;
            r.load_byte  = b.tx;
            phase        = PH_DATA;
          end
        end
        PH_DATA: begin
          if (st != (reading ? ST_R_DATA : ST_W_DATA)) begin
            conclude(r, CMD_STOP, RES_DATA_NACK);
          end else begin
            left = left - 1'b1;
            if (reading) begin
              r.data_valid = 1'b1;
              r.data_byte  = b.rx;
              if (left <= 1) begin
                r.command = CMD_GO;
                phase     = PH_LAST;
              end else begin
                r.command = CMD_ACK;
              end
            end else if (left == 0) begin
              conclude(r, CMD_STOP, RES_OK);
            end else begin
              r.command    = CMD_GO;
              r.load_valid = 1'b1;
              r.load_byte  = b.tx;
            end
          end
        end
        PH_LAST: begin
          if (st != ST_R_LAST) begin
            conclude(r, CMD_STOP, RES_LAST_FAIL);
          end else begin
            r.data_valid = 1'b1;
            r.data_byte  = b.rx;
            left         = '0;
            conclude(r, CMD_STOP, RES_OK);
          end
        end
        default: phase = PH_IDLE;  // event while idle: no reply content
      endcase
      return r;
    endfunction

    function void note_beat(input beat_t b);
      expected_replies.push_back(predict_reply(b));
    endfunction

    task check_reply(input reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report_mismatch("reply beat with nothing pending");
      end else begin
        want = expected_replies.pop_front();
        if (got.command !== want.command)
          report_mismatch($sformatf("command %0d, want %0d", got.command, want.command));
        if (got.load_valid !== want.load_valid)
          report_mismatch($sformatf("load_valid %0d, want %0d", got.load_valid,
                                    want.load_valid));
        if (got.load_byte !== want.load_byte)
          report_mismatch($sformatf("load_byte %02h, want %02h", got.load_byte,
                                    want.load_byte));
        if (got.data_valid !== want.data_valid)
          report_mismatch($sformatf("data_valid %0d, want %0d", got.data_valid,
                                    want.data_valid));
        if (got.data_byte !== want.data_byte)
          report_mismatch($sformatf("data_byte %02h, want %02h", got.data_byte,
                                    want.data_byte));
        if (got.ended !== want.ended)
          report_mismatch($sformatf("done_res %0d, want %0d", got.ended, want.ended));
        if (got.outcome !== want.outcome)
          report_mismatch($sformatf("outcome %0d, want %0d", got.outcome, want.outcome));
      end
      replies_seen++;
    endtask
  endclass

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic       in_stall;
  logic       in_op             = 1'b0;
  logic       in_read_not_write = 1'b0;
  logic [6:0] in_target_address = '0;
  logic [7:0] in_byte_count     = '0;
  logic [7:0] in_status_code    = '0;
  logic [7:0] in_rx_byte        = '0;
  logic [7:0] in_tx_byte        = '0;
  logic       out_valid;
  logic       out_stall         = 1'b0;
  logic [2:0] out_command;
  logic       out_load_valid;
  logic [7:0] out_load_byte;
  logic       out_data_valid;
  logic [7:0] out_data_byte;
  logic       out_done_res;
  logic [2:0] out_outcome;

  int sender_idle_pct   = 14;
  int receiver_idle_pct = 80;
  int useful_beats      = 0;
  int cycles            = 0;

  txn_scoreboard sb = new();

  i2c_master_transaction_sequencer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_read_not_write (in_read_not_write),
    .in_target_address (in_target_address),
    .in_byte_count     (in_byte_count),
    .in_status_code    (in_status_code),
    .in_rx_byte        (in_rx_byte),
    .in_tx_byte        (in_tx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_command       (out_command),
    .out_load_valid    (out_load_valid),
    .out_load_byte     (out_load_byte),
    .out_data_valid    (out_data_valid),
    .out_data_byte     (out_data_byte),
    .out_done_res      (out_done_res),
    .out_outcome       (out_outcome)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("i2c_master_transaction_sequencer_tb: errors");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  // accepted input beats feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_beat({in_op, in_read_not_write, in_target_address, in_byte_count,
                    in_status_code, in_rx_byte, in_tx_byte});
  end

  // accepted reply beats are checked in order
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_reply({out_command, out_load_valid, out_load_byte, out_data_valid,
                      out_data_byte, out_done_res, out_outcome});
  end

  function automatic beat_t random_beat();
    beat_t b;
    b.op     = 1'($urandom);
    b.rnw    = 1'($urandom);
    b.addr   = 7'($urandom);
    b.cnt    = 8'($urandom);
    b.status = 8'($urandom);
    b.rx     = 8'($urandom);
    b.tx     = 8'($urandom);
    return b;
  endfunction

  // drive one beat and hold it until accepted
  task automatic send_beat(input beat_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_op             <= b.op;
    in_read_not_write <= b.rnw;
    in_target_address <= b.addr;
    in_byte_count     <= b.cnt;
    in_status_code    <= b.status;
    in_rx_byte        <= b.rx;
    in_tx_byte        <= b.tx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off the sender until every reply is back; the first edge lets the
  // last accepted beat reach the predictor
  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_idle_event();
    beat_t b;
    b    = random_beat();
    b.op = OP_EVENT;
    send_beat(b);
  endtask

  // One transaction: request, then the bus events the engine would report.
  // fail_at picks the event that carries a wrong status (-1 for none); noise_pct
  // sprinkles requests while busy, which the block must ignore.
  task automatic run_txn(input logic rnw, input logic [6:0] addr, input logic [7:0] cnt,
                         input int fail_at, input int fail_pct, input int noise_pct);
    beat_t                  b;
    logic [COUNT_WIDTH-1:0] n_data;
    logic [7:0]             want;
    int                     n_events;
    int                     k;
    b      = random_beat();
    b.op   = OP_REQUEST;
    b.rnw  = rnw;
    b.addr = addr;
    b.cnt  = cnt;
    send_beat(b);
    useful_beats++;
    n_data   = cnt;
    n_events = 2 + int'(n_data);
    for (k = 0; k < n_events; k++) begin
      if ($urandom_range(99) < noise_pct) begin
        b    = random_beat();
        b.op = OP_REQUEST;
        send_beat(b);
      end
      if (k == 0) want = ST_START;
      else if (k == 1) want = rnw ? ST_R_ADDR : ST_W_ADDR;
      else if (!rnw) want = ST_W_DATA;
      else if (k == n_events - 1) want = ST_R_LAST;
      else want = ST_R_DATA;
      b    = random_beat();
      b.op = OP_EVENT;
      if (k == fail_at || $urandom_range(99) < fail_pct) begin
        while ((b.status & ST_MASK) == want) b.status = 8'($urandom);
        send_beat(b);
        useful_beats++;
        return;
      end
      // low status bits are don't-care
      b.status = want | 8'($urandom_range(7));
      send_beat(b);
      useful_beats++;
    end
  endtask

  initial begin
    int         pass_idx;
    int         goal;
    int         r;
    logic [7:0] cnt;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_idle_event();                          // event while idle
    run_txn(1'b0, 7'h7F, 8'd1, -1, 0, 0);       // write, full address
    run_txn(1'b1, 7'h00, 8'd1, -1, 0, 0);       // single-byte read
    run_txn(1'b1, 7'h55, 8'd0, -1, 0, 0);       // zero-length read
    run_txn(1'b0, 7'h2A, 8'd4, 0, 0, 0);        // start fails
    run_txn(1'b1, 7'h13, 8'd200, 1, 0, 100);    // address nack, requests while busy
    run_txn(1'b1, 7'h6C, 8'd3, 2, 0, 0);        // read data nack
    run_txn(1'b1, 7'h31, 8'd2, 3, 0, 0);        // last read byte fails
    drain_replies();

    // random: three back-pressure regimes
    for (pass_idx = 0; pass_idx < 3; pass_idx++) begin
      sender_idle_pct   = (pass_idx == 0) ? 14 : (pass_idx == 1) ? 80 : 0;
      receiver_idle_pct = (pass_idx == 0) ? 80 : (pass_idx == 1) ? 14 : 0;
      goal = useful_beats + PHASE_BEATS;
      while (useful_beats < goal) begin
        if ($urandom_range(99) < 10) send_idle_event();
        r = $urandom_range(99);
        if (r < 5) cnt = 8'($urandom_range(255, 128));
        else if (r < 30) cnt = 8'($urandom_range(16, 5));
        else cnt = 8'($urandom_range(4, 0));
        run_txn(1'($urandom), 7'($urandom), cnt, -1, 4, 4);
        if ($urandom_range(19) == 0) drain_replies();
      end
      drain_replies();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("i2c_master_transaction_sequencer_tb: clean");
    end else begin
      $display("i2c_master_transaction_sequencer_tb: errors");
    end
    $finish;
  end

endmodule
